FILE: src/vwaf_pkg.sv
// vwaf_pkg: shared types, fixed-point constants and helpers of the virtual wall assist block
// no dependencies; compiled first
`timescale 1ns / 1ps

package vwaf_pkg;

    // operation codes carried by each item
    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_ASCEND  = 2'd1,
        OP_DESCEND = 2'd2,
        OP_SIT     = 2'd3
    } op_e;

    localparam int POS_W   = 16;  // Q3.12 positions
    localparam int FORCE_W = 16;  // Q7.8 forces
    localparam int DEPTH_W = 13;  // wall depth register
    localparam int CALC_W  = 24;  // internal datapath width, exact for all sums

    localparam logic [DEPTH_W-1:0] WALL_DEPTH_RESET = 13'd1229;

    // geometry constants, Q3.12
    localparam logic signed [CALC_W-1:0] C_003 = 24'sd123;
    localparam logic signed [CALC_W-1:0] C_002 = 24'sd82;
    localparam logic signed [CALC_W-1:0] C_02  = 24'sd819;
    localparam logic signed [CALC_W-1:0] C_04  = 24'sd1638;
    localparam logic signed [CALC_W-1:0] C_05  = 24'sd2048;
    localparam logic signed [CALC_W-1:0] C_ZLO = -24'sd614;
    localparam logic signed [CALC_W-1:0] C_ZHI = -24'sd205;

    // force constants, Q7.8
    localparam logic signed [CALC_W-1:0]  F_ONE_W   = 24'sd256;
    localparam logic signed [FORCE_W-1:0] F_ONE     = 16'sd256;
    localparam logic signed [FORCE_W-1:0] F_ASC_Y   = 16'sd3072;
    localparam logic signed [FORCE_W-1:0] F_DOWN_Y  = -16'sd1280;
    localparam logic signed [FORCE_W-1:0] F_SIT_MAX = 16'sd1280;

    // one input item as held in the input register
    typedef struct packed {
        logic [1:0]              op;
        logic signed [POS_W-1:0] obstacle_distance;
        logic signed [POS_W-1:0] obstacle_height;
        logic signed [POS_W-1:0] obstacle_depth;
        logic signed [POS_W-1:0] toe_x;
        logic signed [POS_W-1:0] toe_y;
        logic signed [POS_W-1:0] hip_x;
        logic signed [POS_W-1:0] hip_y;
        logic signed [POS_W-1:0] foot_vel_x;
        logic signed [POS_W-1:0] zmp_x;
    } tick_t;

    // one result item
    typedef struct packed {
        logic                      assist_active;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
    } result_t;

    // clamp to the signed 16-bit force range
    function automatic logic signed [FORCE_W-1:0] sat16(input logic signed [CALC_W-1:0] v);
        logic signed [FORCE_W-1:0] r;
        if (v > 24'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -24'sd32768)
        begin
            r = -16'sh8000;
        end
        else
        begin
            r = v[FORCE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/vwaf_tick_if.sv
// vwaf_tick_if: valid/ready channel carrying one control tick item
// depends on vwaf_pkg for field widths
`timescale 1ns / 1ps

interface vwaf_tick_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic signed [vwaf_pkg::POS_W-1:0] obstacle_distance;
    logic signed [vwaf_pkg::POS_W-1:0] obstacle_height;
    logic signed [vwaf_pkg::POS_W-1:0] obstacle_depth;
    logic signed [vwaf_pkg::POS_W-1:0] toe_x;
    logic signed [vwaf_pkg::POS_W-1:0] toe_y;
    logic signed [vwaf_pkg::POS_W-1:0] hip_x;
    logic signed [vwaf_pkg::POS_W-1:0] hip_y;
    logic signed [vwaf_pkg::POS_W-1:0] foot_vel_x;
    logic signed [vwaf_pkg::POS_W-1:0] zmp_x;

    modport source (
        output valid, op, obstacle_distance, obstacle_height, obstacle_depth,
               toe_x, toe_y, hip_x, hip_y, foot_vel_x, zmp_x,
        input  ready
    );

    modport sink (
        input  valid, op, obstacle_distance, obstacle_height, obstacle_depth,
               toe_x, toe_y, hip_x, hip_y, foot_vel_x, zmp_x,
        output ready
    );
endinterface

FILE: src/vwaf_assist_if.sv
// vwaf_assist_if: valid/ready channel carrying one assist force item
// depends on vwaf_pkg for field widths
`timescale 1ns / 1ps

interface vwaf_assist_if;
    logic                                valid;
    logic                                ready;
    logic                                assist_active;
    logic signed [vwaf_pkg::FORCE_W-1:0] force_x;
    logic signed [vwaf_pkg::FORCE_W-1:0] force_y;

    modport source (
        output valid, assist_active, force_x, force_y,
        input  ready
    );

    modport sink (
        input  valid, assist_active, force_x, force_y,
        output ready
    );
endinterface

FILE: src/vwaf_cfg.sv
// vwaf_cfg: APB-style register block holding the ascend wall depth
// depends on vwaf_pkg
`timescale 1ns / 1ps

module vwaf_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [vwaf_pkg::DEPTH_W-1:0] wall_depth
);

    logic [vwaf_pkg::DEPTH_W-1:0] wall_depth_reg;
    logic [vwaf_pkg::DEPTH_W-1:0] wall_depth_next;
    logic                         wr_en;
    logic                         sel_depth;

    assign pready    = 1'b1;
    assign sel_depth = (paddr[2] == 1'b0);
    assign wr_en     = psel && penable && pwrite && pready && sel_depth;

    always_comb
    begin
        wall_depth_next = wall_depth_reg;
        if (wr_en)
        begin
            wall_depth_next = pwdata[vwaf_pkg::DEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_depth_reg <= vwaf_pkg::WALL_DEPTH_RESET;
        end
        else
        begin
            wall_depth_reg <= wall_depth_next;
        end
    end

    assign prdata     = sel_depth ? {{(32 - vwaf_pkg::DEPTH_W){1'b0}}, wall_depth_reg} : 32'd0;
    assign wall_depth = wall_depth_reg;

endmodule

FILE: src/vwaf_force.sv
// vwaf_force: region test and assist force law for one registered tick
// depends on vwaf_pkg; purely combinational, sits between input and result registers
`timescale 1ns / 1ps

module vwaf_force (
    input  vwaf_pkg::tick_t              tick,
    input  logic [vwaf_pkg::DEPTH_W-1:0] wall_depth,
    input  vwaf_pkg::result_t            held,
    output vwaf_pkg::result_t            result
);

    localparam int W = vwaf_pkg::CALC_W;

    logic signed [W-1:0] d_w, h_w, p_w, tx_w, ty_w, hx_w, hy_w, v_w, z_w, dep_w;

    logic signed [W-1:0] asc_s, asc_xd, asc_lhs, asc_rhs, asc_num, asc_fx;
    logic                asc_in;
    logic signed [W-1:0] dsc_s, dsc_xd, dsc_num, dsc_fx;
    logic                dsc_in;
    logic signed [W-1:0] sit_lin, sit_fx;
    logic                sit_in;

    assign d_w   = W'($signed(tick.obstacle_distance));
    assign h_w   = W'($signed(tick.obstacle_height));
    assign p_w   = W'($signed(tick.obstacle_depth));
    assign tx_w  = W'($signed(tick.toe_x));
    assign ty_w  = W'($signed(tick.toe_y));
    assign hx_w  = W'($signed(tick.hip_x));
    assign hy_w  = W'($signed(tick.hip_y));
    assign v_w   = W'($signed(tick.foot_vel_x));
    assign z_w   = W'($signed(tick.zmp_x));
    assign dep_w = $signed({{(W - vwaf_pkg::DEPTH_W){1'b0}}, wall_depth});

    // ascend: ramp from s to the edge, slope 2/5 compared exactly by scaling by 5
    assign asc_s   = d_w - dep_w;
    assign asc_xd  = tx_w - asc_s;
    assign asc_lhs = 24'sd5 * ty_w;
    assign asc_rhs = 24'sd2 * asc_xd + 24'sd5 * (h_w + vwaf_pkg::C_003) - 24'sd2 * dep_w;
    assign asc_in  = (tx_w > asc_s) && (tx_w < d_w) && (asc_lhs < asc_rhs);
    // -1.5 * (xd + v) in Q7.8, rounded, arithmetic shift is floor
    assign asc_num = 24'sd16 - 24'sd3 * (asc_xd + v_w);
    assign asc_fx  = asc_num >>> 5;

    // descend: box just past the step edge, below the step top
    assign dsc_s   = d_w - p_w;
    assign dsc_xd  = tx_w - dsc_s;
    assign dsc_in  = (tx_w > dsc_s) && (tx_w < dsc_s + vwaf_pkg::C_02)
                  && (ty_w < vwaf_pkg::C_002 - h_w);
    assign dsc_num = 24'sd8 - 24'sd5 * (dsc_xd + v_w);
    assign dsc_fx  = dsc_num >>> 4;

    // sit: hip box above the seat, zmp law clamps at both ends
    assign sit_in  = (hx_w < d_w + vwaf_pkg::C_05) && (hx_w > d_w)
                  && (hy_w < h_w + vwaf_pkg::C_04);
    assign sit_lin = ((24'sd1 - 24'sd5 * z_w) >>> 1) - vwaf_pkg::F_ONE_W;

    always_comb
    begin
        priority if (z_w < vwaf_pkg::C_ZLO)
        begin
            sit_fx = W'(vwaf_pkg::F_SIT_MAX);
        end
        else if (z_w > vwaf_pkg::C_ZHI)
        begin
            sit_fx = vwaf_pkg::F_ONE_W;
        end
        else
        begin
            sit_fx = sit_lin;
        end
    end

    always_comb
    begin
        result = '0;
        unique case (vwaf_pkg::op_e'(tick.op))
            vwaf_pkg::OP_HOLD:
            begin
                result = held;
            end
            vwaf_pkg::OP_ASCEND:
            begin
                if (asc_in)
                begin
                    result.assist_active = 1'b1;
                    result.force_x       = vwaf_pkg::sat16(asc_fx);
                    result.force_y       = vwaf_pkg::F_ASC_Y;
                end
            end
            vwaf_pkg::OP_DESCEND:
            begin
                if (dsc_in)
                begin
                    result.assist_active = 1'b1;
                    result.force_x       = vwaf_pkg::sat16(dsc_fx);
                    result.force_y       = vwaf_pkg::F_DOWN_Y;
                end
            end
            vwaf_pkg::OP_SIT:
            begin
                if (sit_in)
                begin
                    result.assist_active = 1'b1;
                    result.force_x       = vwaf_pkg::sat16(sit_fx);
                    result.force_y       = vwaf_pkg::F_DOWN_Y;
                end
            end
            default:
            begin
                result = held;
            end
        endcase
    end

endmodule

FILE: src/virtual_wall_assist_force.sv
// virtual_wall_assist_force: top level, input register, force logic and result register
// depends on vwaf_pkg, vwaf_tick_if, vwaf_assist_if, vwaf_cfg and vwaf_force
`timescale 1ns / 1ps

// Virtual wall assist force. Each item on the tick channel is one control tick with a
// mode (hold, ascend, descend, sit), the obstacle geometry and the limb positions. The
// block tests whether the swing toe (ascend, descend) or the support hip (sit) lies
// inside a virtual wall region and, if so, returns a saturated Q7.8 assist force with
// assist_active set; outside it returns zero force. A hold tick repeats the last result.
// Throughput is one item per clock while the output is not stalled: the input register
// and the result register are each one stage deep, so a tick taken into the input
// register moves on to the result register as soon as the result slot is free. While a
// finished result waits on a stalled output the input register takes one more tick and
// then the input stalls until the result drains. The only state carried from item to
// item is the last result, which lives in the result register.
// wall_depth (APB offset 0, reset 1229 = 0.3 m) must be written only while idle.

module virtual_wall_assist_force (
    input  logic                clk,
    input  logic                rst_n,
    vwaf_tick_if.sink           tick,
    vwaf_assist_if.source       assist,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    vwaf_pkg::tick_t   in_tick_reg;
    vwaf_pkg::tick_t   in_tick_next;

    // result register; its payload doubles as the held result for hold ticks
    logic              out_valid_reg;
    logic              out_valid_next;
    vwaf_pkg::result_t out_result_reg;
    vwaf_pkg::result_t out_result_next;

    vwaf_pkg::result_t                result;
    logic [vwaf_pkg::DEPTH_W-1:0]     wall_depth;
    logic                             out_free;
    logic                             advance;
    logic                             take_in;

    vwaf_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .wall_depth (wall_depth)
    );

    vwaf_force u_force (
        .tick       (in_tick_reg),
        .wall_depth (wall_depth),
        .held       (out_result_reg),
        .result     (result)
    );

    // result slot is free when empty or being drained this cycle
    assign out_free   = !out_valid_reg || assist.ready;
    assign advance    = in_valid_reg && out_free;
    assign tick.ready = !in_valid_reg || out_free;
    assign take_in    = tick.valid && tick.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_tick_next  = in_tick_reg;
        if (take_in)
        begin
            in_valid_next                  = 1'b1;
            in_tick_next.op                = tick.op;
            in_tick_next.obstacle_distance = tick.obstacle_distance;
            in_tick_next.obstacle_height   = tick.obstacle_height;
            in_tick_next.obstacle_depth    = tick.obstacle_depth;
            in_tick_next.toe_x             = tick.toe_x;
            in_tick_next.toe_y             = tick.toe_y;
            in_tick_next.hip_x             = tick.hip_x;
            in_tick_next.hip_y             = tick.hip_y;
            in_tick_next.foot_vel_x        = tick.foot_vel_x;
            in_tick_next.zmp_x             = tick.zmp_x;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            out_result_next = result;
        end
        else if (assist.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_result_reg <= '0;  // held result starts at zero force, inactive
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            out_result_reg <= out_result_next;
        end
    end

    // tick payload needs no reset
    always_ff @(posedge clk)
    begin
        in_tick_reg <= in_tick_next;
    end

    assign assist.valid         = out_valid_reg;
    assign assist.assist_active = out_result_reg.assist_active;
    assign assist.force_x       = out_result_reg.force_x;
    assign assist.force_y       = out_result_reg.force_y;

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for virtual_wall_assist_force
// depends on vwaf_pkg, vwaf_tick_if, vwaf_assist_if and the block's rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 370;
    localparam int PRINT_LIMIT = 50;

    // register map: wall_depth is the only register
    localparam logic [2:0] REG_WALL_DEPTH = 3'd0;
    localparam logic [12:0] DEPTH_AT_RESET = 13'd1229;

    // geometry constants in Q3.12 metres
    localparam longint Q12_0P03 = 123;
    localparam longint Q12_0P02 = 82;
    localparam longint Q12_0P2 = 819;
    localparam longint Q12_0P4 = 1638;
    localparam longint Q12_0P5 = 2048;
    localparam longint Q12_ZMP_LO = -614;
    localparam longint Q12_ZMP_HI = -205;
    // one newton in Q7.8
    localparam longint Q8_ONE_N = 256;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    vwaf_tick_if tick_ch ();
    vwaf_assist_if assist_ch ();

    virtual_wall_assist_force uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_ch),
        .assist  (assist_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state: our own copy of wall_depth and of the held result
    logic [12:0] depth_model = DEPTH_AT_RESET;
    logic held_on = 1'b0;
    logic signed [15:0] held_fx = '0;
    logic signed [15:0] held_fy = '0;

    // forces still owed by the block, oldest first
    vwaf_pkg::result_t expected_forces[$];

    int error_count = 0;
    int cycle_count = 0;

    // idling controls shared by the test tasks and the two handshake sides
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int rx_stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("virtual_wall_assist_force verification failed");
            $finish;
        end
    end

    // saturate to the signed 16-bit range; used for forces and for stimulus fields
    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767)
        begin
            return 16'sh7FFF;
        end
        if (x < -32768)
        begin
            return -16'sh8000;
        end
        return x[15:0];
    endfunction

    // signed random integer in [lo, hi]
    function automatic int srand(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // back to back half the time, else a short gap, rarely a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return srand(1, 3);
        end
        if (r < 97)
        begin
            return srand(4, 10);
        end
        return srand(11, 40);
    endfunction

    // assist force for one tick; also advances the held result
    function automatic vwaf_pkg::result_t predict_assist(input vwaf_pkg::tick_t t);
        longint d, h, p, tx, ty, hx, hy, v, z, dep, s, xd;
        longint fx, fy;
        logic on;
        vwaf_pkg::result_t r;
        d = longint'(t.obstacle_distance);
        h = longint'(t.obstacle_height);
        p = longint'(t.obstacle_depth);
        tx = longint'(t.toe_x);
        ty = longint'(t.toe_y);
        hx = longint'(t.hip_x);
        hy = longint'(t.hip_y);
        v = longint'(t.foot_vel_x);
        z = longint'(t.zmp_x);
        dep = longint'(depth_model);
        on = 1'b0;
        fx = 0;
        fy = 0;
        case (t.op)
            vwaf_pkg::OP_ASCEND:
            begin
                // ramp of slope 2/5 starting dep before the edge; compare scaled by 5
                s = d - dep;
                xd = tx - s;
                if (tx > s && tx < d && 5 * ty < 2 * xd + 5 * (h + Q12_0P03) - 2 * dep)
                begin
                    on = 1'b1;
                    // -1.5 * (xd + v), q12 to q8 with round half up
                    fx = (-3 * (xd + v) + 16) >>> 5;
                    fy = 12 * Q8_ONE_N;
                end
            end
            vwaf_pkg::OP_DESCEND:
            begin
                s = d - p;
                xd = tx - s;
                if (tx > s && tx < s + Q12_0P2 && ty < -h + Q12_0P02)
                begin
                    on = 1'b1;
                    fx = (-5 * (xd + v) + 8) >>> 4;
                    fy = -5 * Q8_ONE_N;
                end
            end
            vwaf_pkg::OP_SIT:
            begin
                if (hx < d + Q12_0P5 && hx > d && hy < h + Q12_0P4)
                begin
                    on = 1'b1;
                    fy = -5 * Q8_ONE_N;
                    // piecewise zmp law: 5 n, then -40 z - 1 n, then 1 n
                    if (z < Q12_ZMP_LO)
                    begin
                        fx = 5 * Q8_ONE_N;
                    end
                    else if (z > Q12_ZMP_HI)
                    begin
                        fx = Q8_ONE_N;
                    end
                    else
                    begin
                        fx = ((-5 * z + 1) >>> 1) - Q8_ONE_N;
                    end
                end
            end
            default:
            begin
            end
        endcase
        // a hold tick leaves the held result alone
        if (t.op != vwaf_pkg::OP_HOLD)
        begin
            held_on = on;
            held_fx = clamp16(fx);
            held_fy = clamp16(fy);
        end
        r.assist_active = held_on;
        r.force_x = held_fx;
        r.force_y = held_fy;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (error_count < PRINT_LIMIT)
        begin
            $display("mismatch on %s: expected %0d, got %0d (cycle %0d)",
                     what, want, got, cycle_count);
        end
        error_count++;
    endtask

    // accepted ticks become expectations first, so a same-edge result still finds its entry
    always @(posedge clk)
    begin
        vwaf_pkg::tick_t seen;
        vwaf_pkg::result_t want;
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                seen.op = tick_ch.op;
                seen.obstacle_distance = tick_ch.obstacle_distance;
                seen.obstacle_height = tick_ch.obstacle_height;
                seen.obstacle_depth = tick_ch.obstacle_depth;
                seen.toe_x = tick_ch.toe_x;
                seen.toe_y = tick_ch.toe_y;
                seen.hip_x = tick_ch.hip_x;
                seen.hip_y = tick_ch.hip_y;
                seen.foot_vel_x = tick_ch.foot_vel_x;
                seen.zmp_x = tick_ch.zmp_x;
                expected_forces.push_back(predict_assist(seen));
            end
            if (assist_ch.valid && assist_ch.ready)
            begin
                if (expected_forces.size() == 0)
                begin
                    report_mismatch("unexpected item", longint'(0), longint'(0));
                end
                else
                begin
                    want = expected_forces.pop_front();
                    if (assist_ch.assist_active !== want.assist_active)
                    begin
                        report_mismatch("assist_active", longint'(want.assist_active),
                                        longint'(assist_ch.assist_active));
                    end
                    if (assist_ch.force_x !== want.force_x)
                    begin
                        report_mismatch("force_x", longint'(want.force_x),
                                        longint'(assist_ch.force_x));
                    end
                    if (assist_ch.force_y !== want.force_y)
                    begin
                        report_mismatch("force_y", longint'(want.force_y),
                                        longint'(assist_ch.force_y));
                    end
                end
            end
        end
    end

    // receiver: a requested long hold-off wins, else random stalls when idling is on
    always @(posedge clk)
    begin
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_left > 0)
        begin
            assist_ch.ready <= 1'b0;
            rx_hold_left--;
        end
        else if (rx_stall_left > 0)
        begin
            assist_ch.ready <= 1'b0;
            rx_stall_left--;
        end
        else
        begin
            assist_ch.ready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                rx_stall_left = pick_gap() + 1;
            end
        end
    end

    // offer one tick, after an optional gap; valid stays high if the next one follows at once
    task automatic send_tick(input vwaf_pkg::tick_t t);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.op <= t.op;
        tick_ch.obstacle_distance <= t.obstacle_distance;
        tick_ch.obstacle_height <= t.obstacle_height;
        tick_ch.obstacle_depth <= t.obstacle_depth;
        tick_ch.toe_x <= t.toe_x;
        tick_ch.toe_y <= t.toe_y;
        tick_ch.hip_x <= t.hip_x;
        tick_ch.hip_y <= t.hip_y;
        tick_ch.foot_vel_x <= t.foot_vel_x;
        tick_ch.zmp_x <= t.zmp_x;
        do
            @(posedge clk);
        while (!tick_ch.ready);
    endtask

    // stop offering and wait for every owed force, then let the pipe settle
    task automatic wait_quiet();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_forces.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // apb write then read back of wall_depth; only called while the block is idle
    task automatic program_wall_depth(input logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_WALL_DEPTH;
        pwdata <= {19'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        depth_model = value;
        // write lands on this edge; go straight into the read setup
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {19'd0, value})
        begin
            report_mismatch("wall_depth readback", longint'(value), longint'(prdata));
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic vwaf_pkg::tick_t make_tick(input vwaf_pkg::op_e op, input int d,
                                                  input int h, input int p,
                                                  input int tx, input int ty, input int hx,
                                                  input int hy, input int v, input int z);
        vwaf_pkg::tick_t t;
        t.op = op;
        t.obstacle_distance = clamp16(longint'(d));
        t.obstacle_height = clamp16(longint'(h));
        t.obstacle_depth = clamp16(longint'(p));
        t.toe_x = clamp16(longint'(tx));
        t.toe_y = clamp16(longint'(ty));
        t.hip_x = clamp16(longint'(hx));
        t.hip_y = clamp16(longint'(hy));
        t.foot_vel_x = clamp16(longint'(v));
        t.zmp_x = clamp16(longint'(z));
        return t;
    endfunction

    // every field uniform over its whole range
    function automatic vwaf_pkg::tick_t rand_tick();
        vwaf_pkg::tick_t t;
        t.op = 2'($urandom);
        t.obstacle_distance = 16'($urandom);
        t.obstacle_height = 16'($urandom);
        t.obstacle_depth = 16'($urandom);
        t.toe_x = 16'($urandom);
        t.toe_y = 16'($urandom);
        t.hip_x = 16'($urandom);
        t.hip_y = 16'($urandom);
        t.foot_vel_x = 16'($urandom);
        t.zmp_x = 16'($urandom);
        return t;
    endfunction

    // a tick placed around the wall region of its mode, so both sides of every border get hit
    function automatic vwaf_pkg::tick_t shaped_tick(input vwaf_pkg::op_e op);
        vwaf_pkg::tick_t t;
        int d, h, p, s, tx, rhs, dep;
        t = rand_tick();
        t.op = op;
        dep = int'(depth_model);
        d = srand(-16000, 16000);
        h = srand(-12000, 12000);
        t.obstacle_distance = clamp16(longint'(d));
        t.obstacle_height = clamp16(longint'(h));
        case (op)
            vwaf_pkg::OP_ASCEND:
            begin
                s = d - dep;
                tx = s + srand(-40, dep + 40);
                // toe height near the sloped ceiling
                rhs = 2 * (tx - s) + 5 * (h + int'(Q12_0P03)) - 2 * dep;
                t.toe_x = clamp16(longint'(tx));
                t.toe_y = clamp16(longint'(rhs / 5 + srand(-4, 4)
                                           - ($urandom_range(0, 3) == 0 ? 300 : 0)));
            end
            vwaf_pkg::OP_DESCEND:
            begin
                p = srand(-12000, 12000);
                s = d - p;
                t.obstacle_depth = clamp16(longint'(p));
                t.toe_x = clamp16(longint'(s + srand(-40, int'(Q12_0P2) + 40)));
                t.toe_y = clamp16(longint'(-h + int'(Q12_0P02) + srand(-200, 200)));
            end
            vwaf_pkg::OP_SIT:
            begin
                t.hip_x = clamp16(longint'(d + srand(-40, int'(Q12_0P5) + 40)));
                t.hip_y = clamp16(longint'(h + int'(Q12_0P4) + srand(-200, 200)));
                if ($urandom_range(0, 3) != 0)
                begin
                    t.zmp_x = clamp16(longint'(srand(-1000, 300)));
                end
            end
            default:
            begin
            end
        endcase
        return t;
    endfunction

    // hold with nothing computed yet gives zeros; extremes of every field
    task automatic test_hold_from_reset();
        send_tick(make_tick(vwaf_pkg::OP_HOLD, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767));
        send_tick(make_tick(vwaf_pkg::OP_HOLD, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768));
    endtask

    // ascend with the reset depth: edge at 4096, ramp from 2867, ceiling bound at toe_y 1932
    task automatic test_ascend();
        send_tick(make_tick(vwaf_pkg::OP_ASCEND, 4096, 2048, 0, 3500, 0, 0, 0, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_ASCEND, 4096, 2048, 0, 3500, 1932, 0, 0, 100, 0));
        send_tick(make_tick(vwaf_pkg::OP_ASCEND, 4096, 2048, 0, 3500, 1933, 0, 0, 100, 0));
        // toe exactly on the ramp start and on the edge: both outside
        send_tick(make_tick(vwaf_pkg::OP_ASCEND, 4096, 2048, 0, 2867, 0, 0, 0, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_ASCEND, 4096, 2048, 0, 4096, 0, 0, 0, 0, 0));
        // far end of the range with full velocity
        send_tick(make_tick(vwaf_pkg::OP_ASCEND, 32767, 0, 0, 32766, -32768, 0, 0, 32767, 0));
        // hold repeats the inside result
        send_tick(make_tick(vwaf_pkg::OP_HOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // descend: s = 3072, window up to 3891, ceiling below 1082
    task automatic test_descend();
        send_tick(make_tick(vwaf_pkg::OP_DESCEND, 4096, -1000, 1024, 3300, 1081, 0, 0,
                            -32768, 0));
        send_tick(make_tick(vwaf_pkg::OP_DESCEND, 4096, -1000, 1024, 3300, 1082, 0, 0, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_DESCEND, 4096, -1000, 1024, 3890, 0, 0, 0, 500, 0));
        send_tick(make_tick(vwaf_pkg::OP_DESCEND, 4096, -1000, 1024, 3891, 0, 0, 0, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_DESCEND, 4096, -1000, 1024, 3072, 0, 0, 0, 0, 0));
        // hold after an outside tick gives zeros
        send_tick(make_tick(vwaf_pkg::OP_HOLD, 1, 2, 3, 4, 5, 6, 7, 8, 9));
    endtask

    // sit: every zmp branch and both sides of each break point, plus the region borders
    task automatic test_sit();
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1000, 0, 0, -615));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1000, 0, 0, -614));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1000, 0, 0, -205));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1000, 0, 0, -204));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1, 0, 0, 32767));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 2047, -32768, 0, -32768));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 2048, 0, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1000, 1638, 0, 0));
        send_tick(make_tick(vwaf_pkg::OP_SIT, 0, 0, 0, 0, 0, 1000, 1637, 0, 0));
    endtask

    // receiver holds off for a long stretch while ticks keep coming back to back
    task automatic test_output_backpressure();
        int i;
        tx_idle_en = 1'b0;
        rx_hold_req = 80;
        for (i = 0; i < 30; i++)
        begin
            send_tick(shaped_tick(vwaf_pkg::op_e'(srand(1, 3))));
        end
        tx_idle_en = 1'b1;
        wait_quiet();
    endtask

    // random ticks at the current wall depth; the first stretch runs with no idling
    task automatic test_random_phase(input int n);
        int i, r;
        for (i = 0; i < n; i++)
        begin
            tx_idle_en = (i >= 40);
            rx_idle_en = (i >= 40);
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                send_tick(make_tick(vwaf_pkg::OP_HOLD, srand(-32768, 32767),
                                    srand(-32768, 32767),
                                    srand(-32768, 32767), srand(-32768, 32767),
                                    srand(-32768, 32767), srand(-32768, 32767),
                                    srand(-32768, 32767), srand(-32768, 32767),
                                    srand(-32768, 32767)));
            end
            else if (r < 30)
            begin
                send_tick(rand_tick());
            end
            else
            begin
                send_tick(shaped_tick(vwaf_pkg::op_e'(srand(1, 3))));
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // wall depth at its extremes, a random value and back to the reset value
    task automatic test_wall_depth_sweep();
        logic [12:0] depths [4];
        int k;
        depths[0] = 13'd0;
        depths[1] = 13'd8191;
        depths[2] = 13'($urandom_range(1, 8190));
        depths[3] = DEPTH_AT_RESET;
        for (k = 0; k < 4; k++)
        begin
            wait_quiet();
            program_wall_depth(depths[k]);
            // one fixed ascend tick just past the ramp start for this depth
            send_tick(make_tick(vwaf_pkg::OP_ASCEND, 0, 0, 0, -int'(depths[k]) + 1, -32768,
                                0, 0, 0, 0));
            test_random_phase(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.op <= '0;
        tick_ch.obstacle_distance <= '0;
        tick_ch.obstacle_height <= '0;
        tick_ch.obstacle_depth <= '0;
        tick_ch.toe_x <= '0;
        tick_ch.toe_y <= '0;
        tick_ch.hip_x <= '0;
        tick_ch.hip_y <= '0;
        tick_ch.foot_vel_x <= '0;
        tick_ch.zmp_x <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_hold_from_reset();
        test_ascend();
        test_descend();
        test_sit();
        test_output_backpressure();
        // first random phase runs with the depth left at its reset value
        test_random_phase(PHASE_ITEMS);
        test_wall_depth_sweep();

        wait_quiet();
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("virtual_wall_assist_force verification clean");
        end
        else
        begin
            $display("virtual_wall_assist_force verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/vwaf_pkg.sv
src/vwaf_tick_if.sv
src/vwaf_assist_if.sv
src/vwaf_cfg.sv
src/vwaf_force.sv
src/virtual_wall_assist_force.sv
verif/tb_top.sv
